// ----- rtl/hsvrb_pkg.sv -----
// Shared types and constants for the HSV rainbow channel drive pipeline.
// Holds the gamma table, reciprocal constants and the stage payload structs.
// No dependencies.
`timescale 1ns / 1ps

package hsvrb_pkg;

  localparam int unsigned HUE_W    = 9;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [HUE_W-1:0] HUE_MAX = 9'd359;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Reciprocals for exact division by constants over the value ranges in use.
  // Hue: (deg*255+179)/359 with deg <= 359, n < 2^17, shift 25.
  localparam logic [16:0] HUE_RECIP = 17'd93467;
  localparam int unsigned HUE_SHIFT = 25;
  // Saturation: (pct*255+50)/100 with pct <= 100, n < 2^15, shift 22.
  localparam logic [15:0] SAT_RECIP = 16'd41944;
  localparam int unsigned SAT_SHIFT = 22;
  // Drive: (c*g+127)/255 with c, g <= 255, n < 2^16, shift 24.
  localparam logic [16:0] DIV255_RECIP = 17'd65794;
  localparam int unsigned DIV255_SHIFT = 24;

  // Gamma 2.2 curve over 0..100 percent.
  localparam logic [7:0] GAMMA_TAB [0:100] = '{
    8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,
    8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd17,
    8'd18,  8'd19,  8'd21,  8'd22,  8'd24,  8'd25,  8'd27,  8'd29,  8'd30,  8'd32,
    8'd34,  8'd36,  8'd38,  8'd40,  8'd42,  8'd44,  8'd46,  8'd48,  8'd51,  8'd53,
    8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,  8'd71,  8'd74,  8'd77,  8'd80,
    8'd83,  8'd86,  8'd89,  8'd92,  8'd96,  8'd99,  8'd102, 8'd106, 8'd109, 8'd113,
    8'd116, 8'd120, 8'd124, 8'd128, 8'd131, 8'd135, 8'd139, 8'd143, 8'd148, 8'd152,
    8'd156, 8'd160, 8'd165, 8'd169, 8'd174, 8'd178, 8'd183, 8'd188, 8'd192, 8'd197,
    8'd202, 8'd207, 8'd212, 8'd217, 8'd223, 8'd228, 8'd233, 8'd238, 8'd244, 8'd249,
    8'd255
  };

  // Wheel segment codes (hue byte bits 7:5).
  typedef enum logic [2:0] {
    SEG_RED_YEL  = 3'd0,
    SEG_ORANGE   = 3'd1,
    SEG_YEL_GRN  = 3'd2,
    SEG_GRN_AQUA = 3'd3,
    SEG_AQUA_BLU = 3'd4,
    SEG_BLU_PURP = 3'd5,
    SEG_PURP_PNK = 3'd6,
    SEG_PNK_RED  = 3'd7
  } wheel_seg_t;

  // Hue byte, saturation byte and gamma value after the input mapping.
  typedef struct packed {
    logic [7:0] hue_b;
    logic [7:0] sat_b;
    logic [7:0] gain;
  } scale_t;

  // Desaturated wheel color plus gamma value.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gain;
  } color_t;

endpackage

// ----- rtl/hsvrb_scale.sv -----
// Input mapping stages: clamping, byte mapping of hue and saturation, gamma lookup.
// Depends on hsvrb_pkg.
`timescale 1ns / 1ps

module hsvrb_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [8:0]            hue_degrees,
  input  logic [6:0]            sat_percent,
  input  logic [6:0]            brightness_percent,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hsvrb_pkg::scale_t     dn_data
);

  logic        va_r, vb_r;
  logic        en_a, en_b;
  logic [8:0]  hue_c;
  logic [6:0]  sat_c, bri_c;
  logic [16:0] hue_n_nxt, hue_n_r;
  logic [14:0] sat_n_nxt, sat_n_r;
  logic [7:0]  gain_nxt, gain_r;
  logic [33:0] hue_prod;
  logic [30:0] sat_prod;
  hsvrb_pkg::scale_t data_nxt, data_r;

  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  always_comb begin
    hue_c = (hue_degrees > hsvrb_pkg::HUE_MAX) ? hsvrb_pkg::HUE_MAX : hue_degrees;
    sat_c = (sat_percent > hsvrb_pkg::PCT_MAX) ? hsvrb_pkg::PCT_MAX : sat_percent;
    bri_c = (brightness_percent > hsvrb_pkg::PCT_MAX) ? hsvrb_pkg::PCT_MAX
                                                      : brightness_percent;
    hue_n_nxt = 17'(hue_c) * 17'd255 + 17'd179;
    sat_n_nxt = 15'(sat_c) * 15'd255 + 15'd50;
    gain_nxt  = hsvrb_pkg::GAMMA_TAB[bri_c];
  end

  // Division by the constants is a multiply by a reciprocal; the error stays
  // below one remainder step over the clamped ranges, so no correction is needed.
  always_comb begin
    hue_prod = 34'(hue_n_r) * 34'(hsvrb_pkg::HUE_RECIP);
    sat_prod = 31'(sat_n_r) * 31'(hsvrb_pkg::SAT_RECIP);
    data_nxt.hue_b = hue_prod[hsvrb_pkg::HUE_SHIFT +: 8];
    data_nxt.sat_b = sat_prod[hsvrb_pkg::SAT_SHIFT +: 8];
    data_nxt.gain  = gain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      hue_n_r <= hue_n_nxt;
      sat_n_r <= sat_n_nxt;
      gain_r  <= gain_nxt;
    end
    if (en_b) data_r <= data_nxt;
  end

  assign dn_valid = vb_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/hsvrb_wheel.sv -----
// Rainbow hue wheel and desaturation stages.
// Depends on hsvrb_pkg.
`timescale 1ns / 1ps

module hsvrb_wheel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  hsvrb_pkg::scale_t     up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hsvrb_pkg::color_t     dn_data
);

  logic        va_r, vb_r;
  logic        en_a, en_b;
  logic [7:0]  off8;
  logic [15:0] t1_prod, t2_prod;
  logic [7:0]  t1, t2;
  logic [7:0]  d, desat_nxt, keep_nxt;
  logic [15:0] dd;
  hsvrb_pkg::wheel_seg_t seg;
  hsvrb_pkg::color_t wheel_nxt, wheel_r, data_nxt, data_r;
  logic [7:0]  desat_r, keep_r;
  logic        sat_zero_r, sat_full_r;
  logic [16:0] rp, gp, bp;

  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  always_comb begin
    off8    = {up_data.hue_b[4:0], 3'b000};
    t1_prod = 16'(off8) * 16'd86;
    t2_prod = 16'(off8) * 16'd171;
    t1      = t1_prod[15:8];
    t2      = t2_prod[15:8];
    seg     = hsvrb_pkg::wheel_seg_t'(up_data.hue_b[7:5]);
    wheel_nxt.gain = up_data.gain;
    unique case (seg)
      hsvrb_pkg::SEG_RED_YEL: begin
        wheel_nxt.red = 8'd255 - t1; wheel_nxt.green = t1; wheel_nxt.blue = 8'd0;
      end
      hsvrb_pkg::SEG_ORANGE: begin
        wheel_nxt.red = 8'd171; wheel_nxt.green = 8'd85 + t1; wheel_nxt.blue = 8'd0;
      end
      hsvrb_pkg::SEG_YEL_GRN: begin
        wheel_nxt.red = 8'd171 - t2; wheel_nxt.green = 8'd170 + t1;
        wheel_nxt.blue = 8'd0;
      end
      hsvrb_pkg::SEG_GRN_AQUA: begin
        wheel_nxt.red = 8'd0; wheel_nxt.green = 8'd255 - t1; wheel_nxt.blue = t1;
      end
      hsvrb_pkg::SEG_AQUA_BLU: begin
        wheel_nxt.red = 8'd0; wheel_nxt.green = 8'd171 - t2;
        wheel_nxt.blue = 8'd85 + t2;
      end
      hsvrb_pkg::SEG_BLU_PURP: begin
        wheel_nxt.red = t1; wheel_nxt.green = 8'd0; wheel_nxt.blue = 8'd255 - t1;
      end
      hsvrb_pkg::SEG_PURP_PNK: begin
        wheel_nxt.red = 8'd85 + t1; wheel_nxt.green = 8'd0;
        wheel_nxt.blue = 8'd171 - t1;
      end
      default: begin
        wheel_nxt.red = 8'd170 + t1; wheel_nxt.green = 8'd0;
        wheel_nxt.blue = 8'd85 - t1;
      end
    endcase
    // Desaturation amount grows with the square of the distance from full saturation.
    d         = 8'd255 - up_data.sat_b;
    dd        = 16'(d) * 16'(d);
    desat_nxt = dd[15:8] + 8'd1;
    keep_nxt  = 8'd255 - desat_nxt;
  end

  always_comb begin
    rp = 17'(wheel_r.red)   * (17'(keep_r) + 17'd1);
    gp = 17'(wheel_r.green) * (17'(keep_r) + 17'd1);
    bp = 17'(wheel_r.blue)  * (17'(keep_r) + 17'd1);
    data_nxt.gain = wheel_r.gain;
    priority if (sat_zero_r) begin
      data_nxt.red   = 8'd255;
      data_nxt.green = 8'd255;
      data_nxt.blue  = 8'd255;
    end else if (sat_full_r) begin
      data_nxt.red   = wheel_r.red;
      data_nxt.green = wheel_r.green;
      data_nxt.blue  = wheel_r.blue;
    end else begin
      data_nxt.red   = rp[15:8] + desat_r;
      data_nxt.green = gp[15:8] + desat_r;
      data_nxt.blue  = bp[15:8] + desat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      wheel_r    <= wheel_nxt;
      desat_r    <= desat_nxt;
      keep_r     <= keep_nxt;
      sat_zero_r <= (up_data.sat_b == 8'd0);
      sat_full_r <= (up_data.sat_b == 8'd255);
    end
    if (en_b) data_r <= data_nxt;
  end

  assign dn_valid = vb_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/hsvrb_gamma.sv -----
// Brightness scaling stages: product with the gamma value, rounded division by 255.
// Depends on hsvrb_pkg.
`timescale 1ns / 1ps

module hsvrb_gamma (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  hsvrb_pkg::color_t     up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [7:0]            red_drive,
  output logic [7:0]            green_drive,
  output logic [7:0]            blue_drive
);

  logic        va_r, vb_r;
  logic        en_a, en_b;
  logic [15:0] rn_nxt, gn_nxt, bn_nxt, rn_r, gn_r, bn_r;
  logic [32:0] rq, gq, bq;
  logic [7:0]  red_r, green_r, blue_r;

  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  // Largest numerator is 255*255+127, which fits in 16 bits.
  always_comb begin
    rn_nxt = 16'(up_data.red)   * 16'(up_data.gain) + 16'd127;
    gn_nxt = 16'(up_data.green) * 16'(up_data.gain) + 16'd127;
    bn_nxt = 16'(up_data.blue)  * 16'(up_data.gain) + 16'd127;
    rq     = 33'(rn_r) * 33'(hsvrb_pkg::DIV255_RECIP);
    gq     = 33'(gn_r) * 33'(hsvrb_pkg::DIV255_RECIP);
    bq     = 33'(bn_r) * 33'(hsvrb_pkg::DIV255_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      rn_r <= rn_nxt;
      gn_r <= gn_nxt;
      bn_r <= bn_nxt;
    end
    if (en_b) begin
      red_r   <= rq[hsvrb_pkg::DIV255_SHIFT +: 8];
      green_r <= gq[hsvrb_pkg::DIV255_SHIFT +: 8];
      blue_r  <= bq[hsvrb_pkg::DIV255_SHIFT +: 8];
    end
  end

  assign dn_valid    = vb_r;
  assign red_drive   = red_r;
  assign green_drive = green_r;
  assign blue_drive  = blue_r;

endmodule

// ----- rtl/hsv_rainbow_channel_drive.sv -----
// Top level of the HSV rainbow channel drive: stream ports around three pipeline parts.
// Depends on hsvrb_pkg, hsvrb_scale, hsvrb_wheel and hsvrb_gamma.
`timescale 1ns / 1ps

// This block turns one pixel item of hue in degrees, saturation in percent and
// brightness in percent into three 8-bit channel drives along an eight-segment
// rainbow hue wheel with gamma 2.2 brightness. Out-of-range inputs saturate to
// 359 degrees and 100 percent. It accepts one item every clock cycle unless a
// stalled output has filled the pipeline. The six register stages are input
// mapping, reciprocal division, wheel lookup, desaturation, gamma product and
// division by 255. Every stage has its own valid bit and advances when the
// stage after it is empty or moving, so a stalled output holds its item and the
// stages behind it fill up before in_tready falls. There is no configuration
// and no state other than the pipeline contents.
module hsv_rainbow_channel_drive (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [8:0] hue_degrees, [15:9] sat_percent, [22:16] brightness_percent, [23] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] red_drive, [15:8] green_drive, [23:16] blue_drive
  output logic [23:0] out_tdata
);

  logic              scale_valid, scale_ready;
  logic              wheel_valid, wheel_ready;
  hsvrb_pkg::scale_t scale_data;
  hsvrb_pkg::color_t wheel_data;
  logic [7:0]        red_drive, green_drive, blue_drive;

  hsvrb_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (in_tvalid),
    .up_ready           (in_tready),
    .hue_degrees        (in_tdata[8:0]),
    .sat_percent        (in_tdata[15:9]),
    .brightness_percent (in_tdata[22:16]),
    .dn_valid           (scale_valid),
    .dn_ready           (scale_ready),
    .dn_data            (scale_data)
  );

  hsvrb_wheel u_wheel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (scale_valid),
    .up_ready (scale_ready),
    .up_data  (scale_data),
    .dn_valid (wheel_valid),
    .dn_ready (wheel_ready),
    .dn_data  (wheel_data)
  );

  hsvrb_gamma u_gamma (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (wheel_valid),
    .up_ready    (wheel_ready),
    .up_data     (wheel_data),
    .dn_valid    (out_tvalid),
    .dn_ready    (out_tready),
    .red_drive   (red_drive),
    .green_drive (green_drive),
    .blue_drive  (blue_drive)
  );

  assign out_tdata = {blue_drive, green_drive, red_drive};

  // Reset empties the whole pipeline, so no result appears right after it.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A moving output frees every stage, so the input side must be open too.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output is taken");

  // An idle pipeline with an open output can never block the input.
  a_empty_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && !wheel_valid && !scale_valid) |-> in_tready)
    else $error("input blocked with an empty pipeline");

endmodule
